@@ hw/rtl/crcpr_pkg.sv @@
// shared types, codes and the crc byte update for the crc checked page reader
package crcpr_pkg;

    localparam int MAX_PAGE_BYTES = 256;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] RST_START_ADDR = 16'h0000;
    localparam logic [15:0] RST_STOP_ADDR  = 16'h0000;
    localparam logic [8:0]  RST_PAYLOAD    = 9'd256;
    localparam logic [15:0] RST_CRC_SEED   = 16'h0001;

    localparam logic [1:0] CFG_START_ADDR = 2'd0;
    localparam logic [1:0] CFG_STOP_ADDR  = 2'd1;
    localparam logic [1:0] CFG_PAYLOAD    = 2'd2;
    localparam logic [1:0] CFG_CRC_SEED   = 2'd3;

    typedef enum logic [1:0] {
        REQ_START   = 2'd0,
        REQ_BYTE    = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_PAGE = 2'd0,
        KIND_DATA = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_CRC_ERR = 2'd2
    } t_status;

    typedef struct packed {
        t_req       req;
        logic [7:0] rx_byte;
    } t_cmd;

    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_wr;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] page_address;
        logic [7:0]  data_byte;
        logic [7:0]  byte_offset;
        t_status     status;
    } t_result;

    function automatic logic [15:0] crc_push8(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        logic [7:0]  d;
        logic        carry;
        c = crc;
        d = data;
        for (int i = 0; i < 8; i++) begin
            carry = c[15];
            c     = {c[14:0], d[7]};
            d     = {d[6:0], 1'b0};
            if (carry) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/crcpr_front.sv @@
// input stage: takes requests, drops unused codes, hands them to the queue
module crcpr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // rx_byte
    input  logic [1:0]         s_axis_tuser,   // req_type
    output logic               o_push,
    output crcpr_pkg::t_cmd    o_cmd,
    input  logic               i_push_ready
);

    logic            r_vld;
    crcpr_pkg::t_cmd r_cmd;
    logic            take;
    crcpr_pkg::t_req req;

    assign req           = crcpr_pkg::t_req'(s_axis_tuser);
    assign s_axis_tready = !r_vld || i_push_ready;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_vld <= take && (req != crcpr_pkg::REQ_NONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd.req     <= req;
            r_cmd.rx_byte <= s_axis_tdata;
        end
    end

    assign o_push = r_vld;
    assign o_cmd  = r_cmd;

endmodule

@@ hw/rtl/crcpr_queue.sv @@
// small request queue between the input stage and the page engine
module crcpr_queue #(
    parameter int DEPTH = crcpr_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  crcpr_pkg::t_cmd i_cmd,
    output logic            o_push_ready,
    output logic            o_vld,
    output crcpr_pkg::t_cmd o_cmd,
    input  logic            i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    crcpr_pkg::t_cmd  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_vld        = (r_count != '0);
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_vld;
    assign o_cmd        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

endmodule

@@ hw/rtl/crcpr_engine.sv @@
// page engine: transfer state, crc check, config registers and result register
module crcpr_engine #(
    parameter int MAX_PAGE_BYTES = crcpr_pkg::MAX_PAGE_BYTES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crcpr_pkg::t_cfg_wr i_cfg,
    input  logic               i_q_vld,
    input  crcpr_pkg::t_cmd    i_q_cmd,
    output logic               o_q_pop,
    output logic               o_vld,
    input  logic               i_ready,
    output crcpr_pkg::t_result o_res
);

    localparam int CNT_W = $clog2(MAX_PAGE_BYTES + 2);

    logic [15:0] r_start_addr;
    logic [15:0] r_stop_addr;
    logic [8:0]  r_payload_len;
    logic [15:0] r_crc_seed;

    logic             r_active;
    logic [CNT_W-1:0] r_count;
    logic [15:0]      r_crc;
    logic [7:0]       r_crc_low;
    logic [15:0]      r_addr;

    logic             n_active;
    logic [CNT_W-1:0] n_count;
    logic [15:0]      n_crc;
    logic [7:0]       n_crc_low;
    logic [15:0]      n_addr;

    logic               r_out_vld;
    crcpr_pkg::t_result r_out;

    logic               pop;
    logic               res_vld;
    crcpr_pkg::t_result res;
    logic [31:0]        plen;
    logic [31:0]        len_w;
    logic [CNT_W-1:0]   len;
    logic [15:0]        crc_aug;
    logic [15:0]        next_addr;

    assign pop     = i_q_vld && (!r_out_vld || i_ready);
    assign o_q_pop = pop;

    // effective page length
    always_comb begin
        plen = 32'(r_payload_len);
        if (plen == 32'd0) begin
            len_w = 32'd1;
        end else if (plen > 32'(MAX_PAGE_BYTES)) begin
            len_w = 32'(MAX_PAGE_BYTES);
        end else begin
            len_w = plen;
        end
        len = CNT_W'(len_w);
    end

    assign crc_aug   = crcpr_pkg::crc_push8(crcpr_pkg::crc_push8(r_crc, 8'h00), 8'h00);
    assign next_addr = r_addr + 16'(len);

    always_comb begin
        n_active  = r_active;
        n_count   = r_count;
        n_crc     = r_crc;
        n_crc_low = r_crc_low;
        n_addr    = r_addr;
        res_vld   = 1'b0;
        res       = '0;
        if (pop) begin
            case (i_q_cmd.req)
                crcpr_pkg::REQ_START: begin
                    n_addr  = r_start_addr;
                    res_vld = 1'b1;
                    if (r_start_addr == r_stop_addr) begin
                        n_active   = 1'b0;
                        res.kind   = crcpr_pkg::KIND_DONE;
                        res.status = crcpr_pkg::ST_OK;
                    end else begin
                        n_active         = 1'b1;
                        n_count          = '0;
                        n_crc            = r_crc_seed;
                        res.kind         = crcpr_pkg::KIND_PAGE;
                        res.page_address = r_start_addr;
                    end
                end
                crcpr_pkg::REQ_TIMEOUT: begin
                    if (r_active) begin
                        n_active   = 1'b0;
                        res_vld    = 1'b1;
                        res.kind   = crcpr_pkg::KIND_DONE;
                        res.status = crcpr_pkg::ST_TIMEOUT;
                    end
                end
                crcpr_pkg::REQ_BYTE: begin
                    if (r_active) begin
                        if (r_count < len) begin
                            n_crc           = crcpr_pkg::crc_push8(r_crc, i_q_cmd.rx_byte);
                            n_count         = r_count + 1'b1;
                            res_vld         = 1'b1;
                            res.kind        = crcpr_pkg::KIND_DATA;
                            res.data_byte   = i_q_cmd.rx_byte;
                            res.byte_offset = 8'(r_count);
                        end else if (r_count == len) begin
                            n_crc_low = i_q_cmd.rx_byte;
                            n_count   = r_count + 1'b1;
                        end else begin
                            n_crc   = crc_aug;
                            res_vld = 1'b1;
                            if (crc_aug != {i_q_cmd.rx_byte, r_crc_low}) begin
                                n_active   = 1'b0;
                                res.kind   = crcpr_pkg::KIND_DONE;
                                res.status = crcpr_pkg::ST_CRC_ERR;
                            end else if (next_addr == r_stop_addr) begin
                                n_addr     = next_addr;
                                n_active   = 1'b0;
                                res.kind   = crcpr_pkg::KIND_DONE;
                                res.status = crcpr_pkg::ST_OK;
                            end else begin
                                n_addr           = next_addr;
                                n_count          = '0;
                                n_crc            = r_crc_seed;
                                res.kind         = crcpr_pkg::KIND_PAGE;
                                res.page_address = next_addr;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_addr  <= crcpr_pkg::RST_START_ADDR;
            r_stop_addr   <= crcpr_pkg::RST_STOP_ADDR;
            r_payload_len <= crcpr_pkg::RST_PAYLOAD;
            r_crc_seed    <= crcpr_pkg::RST_CRC_SEED;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                crcpr_pkg::CFG_START_ADDR: r_start_addr  <= i_cfg.data;
                crcpr_pkg::CFG_STOP_ADDR:  r_stop_addr   <= i_cfg.data;
                crcpr_pkg::CFG_PAYLOAD:    r_payload_len <= i_cfg.data[8:0];
                crcpr_pkg::CFG_CRC_SEED:   r_crc_seed    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_count   <= '0;
            r_crc     <= '0;
            r_crc_low <= '0;
            r_addr    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_active  <= n_active;
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_crc_low <= n_crc_low;
            r_addr    <= n_addr;
            if (pop) begin
                r_out_vld <= res_vld;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && res_vld) begin
            r_out <= res;
        end
    end

    assign o_vld = r_out_vld;
    assign o_res = r_out;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.kind == crcpr_pkg::KIND_DONE) |-> !r_active)
        else $error("finish result while transfer still active");

    a_page_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.kind == crcpr_pkg::KIND_PAGE) |-> (r_active && r_count == '0))
        else $error("page request without fresh page state");

    a_new_from_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(pop))
        else $error("result appeared without a request");

endmodule

@@ hw/rtl/crc_checked_page_reader_top.sv @@
// a request goes through the input register, the queue and the output register
// throughput: one request per cycle with no stall, one crc byte update per cycle in the engine
// requests with no result still reach the engine, but req_type none is dropped at the input
// the engine pops only while the output register is empty or its result is being taken
// reset: synchronous active low; clears queue and transfer state, config to defaults
module crc_checked_page_reader_top #(
    parameter int MAX_PAGE_BYTES = crcpr_pkg::MAX_PAGE_BYTES,
    parameter int QUEUE_DEPTH    = crcpr_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic [1:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // page_address, data_byte, byte_offset, status, zero pad
    output logic [1:0]  m_axis_tuser    // kind
);

    logic               push;
    crcpr_pkg::t_cmd    push_cmd;
    logic               push_ready;
    logic               q_vld;
    crcpr_pkg::t_cmd    q_cmd;
    logic               q_pop;
    crcpr_pkg::t_cfg_wr cfg;
    crcpr_pkg::t_result res;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_wdata;

    crcpr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push        (push),
        .o_cmd         (push_cmd),
        .i_push_ready  (push_ready)
    );

    crcpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .o_push_ready (push_ready),
        .o_vld        (q_vld),
        .o_cmd        (q_cmd),
        .i_pop        (q_pop)
    );

    crcpr_engine #(
        .MAX_PAGE_BYTES (MAX_PAGE_BYTES)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_q_vld (q_vld),
        .i_q_cmd (q_cmd),
        .o_q_pop (q_pop),
        .o_vld   (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tdata = {6'b0, res.status, res.byte_offset, res.data_byte, res.page_address};

endmodule

@@ sim/page_read_checker.sv @@
// checker for the crc checked page reader: predicts results from observed requests and compares
module page_read_checker
    import crcpr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [7:0]  i_req_data,
    input  logic [1:0]  i_req_user,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [39:0] i_res_data,
    input  logic [1:0]  i_res_user,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [15:0] GEN_POLY  = 16'h1021;
    localparam logic [8:0]  PAGE_MAX  = 9'(MAX_PAGE_BYTES);

    typedef struct packed {
        t_kind       kind;
        logic [15:0] page_address;
        logic [7:0]  data_byte;
        logic [7:0]  byte_offset;
        t_status     status;
    } t_reader_result;

    logic [15:0] cfg_start;
    logic [15:0] cfg_stop;
    logic [8:0]  cfg_len;
    logic [15:0] cfg_seed;

    logic        reading_active;
    logic [8:0]  page_bytes_seen;
    logic [15:0] crc_acc;
    logic [7:0]  crc_low_byte;
    logic [15:0] page_addr;

    t_reader_result expected_results[$];
    t_reader_result want;
    int             mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic [15:0] crc_shift_byte(input logic [15:0] acc, input logic [7:0] din);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15];
            r  = {r[14:0], din[k]};
            if (fb) begin
                r = r ^ GEN_POLY;
            end
        end
        return r;
    endfunction

    task automatic finish_transfer(input t_status st);
        reading_active = 1'b0;
        expected_results.push_back('{KIND_DONE, 16'h0000, 8'h00, 8'h00, st});
    endtask

    task automatic ask_for_page();
        reading_active  = 1'b1;
        page_bytes_seen = 9'd0;
        crc_acc         = cfg_seed;
        expected_results.push_back('{KIND_PAGE, page_addr, 8'h00, 8'h00, ST_OK});
    endtask

    task automatic advance_reader(input t_req req, input logic [7:0] rx);
        logic [8:0]  len;
        logic [15:0] full_crc;
        len = (cfg_len == 9'd0) ? 9'd1 : (cfg_len > PAGE_MAX) ? PAGE_MAX : cfg_len;
        case (req)
            REQ_START: begin
                page_addr = cfg_start;
                if (page_addr == cfg_stop) begin
                    finish_transfer(ST_OK);
                end else begin
                    ask_for_page();
                end
            end
            REQ_TIMEOUT: begin
                if (reading_active) begin
                    finish_transfer(ST_TIMEOUT);
                end
            end
            REQ_BYTE: begin
                if (!reading_active) begin
                end else if (page_bytes_seen < len) begin
                    expected_results.push_back('{KIND_DATA, 16'h0000, rx, page_bytes_seen[7:0],
                                                 ST_OK});
                    crc_acc         = crc_shift_byte(crc_acc, rx);
                    page_bytes_seen = page_bytes_seen + 9'd1;
                end else if (page_bytes_seen == len) begin
                    crc_low_byte    = rx;
                    page_bytes_seen = page_bytes_seen + 9'd1;
                end else begin
                    // augmented check: two zero bytes pushed before the compare
                    full_crc = crc_shift_byte(crc_shift_byte(crc_acc, 8'h00), 8'h00);
                    crc_acc  = full_crc;
                    if (full_crc != {rx, crc_low_byte}) begin
                        finish_transfer(ST_CRC_ERR);
                    end else begin
                        page_addr = page_addr + 16'(len);
                        if (page_addr == cfg_stop) begin
                            finish_transfer(ST_OK);
                        end else begin
                            ask_for_page();
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string label, input logic [15:0] exp_v,
                                 input logic [15:0] got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, label, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_start       = 16'h0000;
            cfg_stop        = 16'h0000;
            cfg_len         = 9'd256;
            cfg_seed        = 16'h0001;
            reading_active  = 1'b0;
            page_bytes_seen = 9'd0;
            crc_acc         = 16'h0000;
            crc_low_byte    = 8'h00;
            page_addr       = 16'h0000;
            expected_results.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_ADDR: cfg_start = i_cfg_wdata;
                    CFG_STOP_ADDR:  cfg_stop  = i_cfg_wdata;
                    CFG_PAYLOAD:    cfg_len   = i_cfg_wdata[8:0];
                    CFG_CRC_SEED:   cfg_seed  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result expected none actual kind %0d data %h",
                             $time, i_res_user, i_res_data);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("kind", 16'(want.kind), 16'(i_res_user));
                    compare_field("page_address", want.page_address, i_res_data[15:0]);
                    compare_field("data_byte", 16'(want.data_byte), 16'(i_res_data[23:16]));
                    compare_field("byte_offset", 16'(want.byte_offset),
                                  16'(i_res_data[31:24]));
                    compare_field("status", 16'(want.status), 16'(i_res_data[33:32]));
                end
            end
            if (i_req_valid && i_req_ready) begin
                advance_reader(t_req'(i_req_user), i_req_data);
            end
            o_pending <= expected_results.size();
        end
    end

endmodule

@@ sim/crc_checked_page_reader_top_tb.sv @@
// testbench top for the crc checked page reader: clock, reset, request stimulus and verdict
module crc_checked_page_reader_top_tb;

    import crcpr_pkg::*;

    localparam int LONG_HOLD = 120;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = CFG_START_ADDR;
    logic [15:0] i_cfg_wdata   = 16'h0000;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic [1:0]  s_axis_tuser  = REQ_NONE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int          checker_fails;
    int          checker_pending;
    int          requests_sent = 0;
    int          cur_len       = 256;
    logic [15:0] cur_seed      = 16'h0001;
    logic [15:0] page_crc      = 16'h0000;
    bit          quiet         = 1'b0;
    bit          hold_pending  = 1'b0;

    always #6 i_clk = ~i_clk;

    crc_checked_page_reader_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    page_read_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .o_fail_count (checker_fails),
        .o_pending    (checker_pending)
    );

    function automatic logic [15:0] page_crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] acc;
        logic [7:0]  sh;
        acc = c;
        sh  = b;
        repeat (8) begin
            acc = acc[15] ? ({acc[14:0], sh[7]} ^ 16'h1021) : {acc[14:0], sh[7]};
            sh  = sh << 1;
        end
        return acc;
    endfunction

    task automatic push_request(input t_req req, input logic [7:0] b);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (checker_pending != 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic setup_regs(input logic [15:0] first, input logic [15:0] last,
                              input logic [8:0] raw_len, input logic [15:0] seed);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_START_ADDR;
        i_cfg_wdata <= first;
        @(posedge i_clk);
        i_cfg_index <= CFG_STOP_ADDR;
        i_cfg_wdata <= last;
        @(posedge i_clk);
        i_cfg_index <= CFG_PAYLOAD;
        i_cfg_wdata <= {7'd0, raw_len};
        @(posedge i_clk);
        i_cfg_index <= CFG_CRC_SEED;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_len  = (raw_len == 0) ? 1 : (raw_len > MAX_PAGE_BYTES) ? MAX_PAGE_BYTES : raw_len;
        cur_seed = seed;
    endtask

    task automatic send_payload(input int n);
        logic [7:0] b;
        repeat (n) begin
            b        = 8'($urandom_range(0, 255));
            page_crc = page_crc_step(page_crc, b);
            push_request(REQ_BYTE, b);
        end
    endtask

    task automatic send_page(input bit corrupt);
        logic [15:0] c;
        page_crc = cur_seed;
        send_payload(cur_len);
        c = page_crc_step(page_crc_step(page_crc, 8'h00), 8'h00);
        if (corrupt) begin
            c = c ^ (16'h0001 << $urandom_range(0, 15));
        end
        push_request(REQ_BYTE, c[7:0]);
        push_request(REQ_BYTE, c[15:8]);
    endtask

    task automatic run_transfer(input int pages, input bit endless);
        bit ended;
        ended = 1'b0;
        push_request(REQ_START, 8'($urandom_range(0, 255)));
        for (int k = 0; k < pages && !ended; k++) begin
            case ($urandom_range(0, 19))
                0: begin
                    page_crc = cur_seed;
                    send_payload($urandom_range(0, cur_len + 1));
                    push_request(REQ_TIMEOUT, 8'($urandom_range(0, 255)));
                    ended = 1'b1;
                end
                1: begin
                    send_page(1'b1);
                    ended = 1'b1;
                end
                2: begin
                    // restart while a page is still arriving
                    page_crc = cur_seed;
                    send_payload($urandom_range(0, cur_len));
                    push_request(REQ_START, 8'($urandom_range(0, 255)));
                    ended = 1'b1;
                end
                default: send_page(1'b0);
            endcase
        end
        if (endless && !ended) begin
            push_request(REQ_TIMEOUT, 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_pending = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 10);
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int          pick;
        int          raw;
        int          pages;
        int          transfers;
        bit          endless;
        logic [15:0] first;
        logic [15:0] last;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle requests are dropped, then start equal to stop at reset values
        push_request(REQ_BYTE, 8'hFF);
        push_request(REQ_TIMEOUT, 8'h00);
        push_request(REQ_NONE, 8'hFF);
        push_request(REQ_START, 8'h00);

        // zero length read as one, address wraps past the top
        wait_idle();
        setup_regs(16'hFFFF, 16'h0001, 9'd0, 16'h0000);
        push_request(REQ_START, 8'h00);
        send_page(1'b0);
        send_page(1'b0);

        // restart mid page, then timeout on a stop that is never reached
        wait_idle();
        setup_regs(16'h1234, 16'h0000, 9'd1, 16'hFFFF);
        push_request(REQ_START, 8'h00);
        page_crc = cur_seed;
        send_payload(1);
        push_request(REQ_START, 8'h00);
        send_page(1'b0);
        push_request(REQ_TIMEOUT, 8'h00);

        // crc mismatch
        wait_idle();
        setup_regs(16'h8000, 16'h8004, 9'd2, 16'h5A5A);
        push_request(REQ_START, 8'h00);
        send_page(1'b1);

        // length shrinks while a page is half received
        wait_idle();
        setup_regs(16'h0000, 16'h0004, 9'd4, 16'h0001);
        push_request(REQ_START, 8'h00);
        page_crc = cur_seed;
        send_payload(2);
        wait_idle();
        setup_regs(16'h0000, 16'h0004, 9'd1, 16'h0001);
        push_request(REQ_BYTE, 8'($urandom_range(0, 255)));
        push_request(REQ_BYTE, 8'($urandom_range(0, 255)));
        push_request(REQ_NONE, 8'h00);

        // oversized length clamps to a full page, sink held off meanwhile
        wait_idle();
        setup_regs(16'hFF00, 16'h0000, 9'd511, 16'($urandom_range(0, 65535)));
        hold_pending = 1'b1;
        run_transfer(1, 1'b0);

        while (requests_sent < 1700) begin
            if (requests_sent >= 1450) begin
                quiet = 1'b1;
            end
            wait_idle();
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                raw = $urandom_range(65, 511);
            end else if (pick < 5) begin
                raw = 0;
            end else if (pick < 20) begin
                raw = $urandom_range(17, 64);
            end else begin
                raw = $urandom_range(1, 16);
            end
            first   = 16'($urandom_range(0, 65535));
            endless = ($urandom_range(0, 9) == 0);
            setup_regs(first, 16'h0000, raw[8:0], 16'($urandom_range(0, 65535)));
            pages     = (cur_len > 64) ? $urandom_range(0, 1) : $urandom_range(0, 3);
            transfers = (cur_len > 64) ? 1 : $urandom_range(1, 3);
            if (endless) begin
                pages = (pages == 0) ? 1 : pages;
                last  = first + 16'hFFFF;
            end else begin
                last  = first + 16'(cur_len * pages);
            end
            setup_regs(first, last, raw[8:0], cur_seed);
            repeat (transfers) begin
                run_transfer(pages, endless);
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        case ($urandom_range(0, 2))
                            0: push_request(REQ_BYTE, 8'($urandom_range(0, 255)));
                            1: push_request(REQ_TIMEOUT, 8'($urandom_range(0, 255)));
                            default: push_request(REQ_NONE, 8'($urandom_range(0, 255)));
                        endcase
                        requests_sent--;
                    end
                end
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (checker_fails == 0 && checker_pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
